FILE: design/cdq_pkg.sv
// Package: command and status codes and the status bundle of the deque.
package cdq_pkg;

	typedef enum logic [1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		status_t status;
		logic    empty;
		logic    full;
	} info_t;

	localparam int unsigned WORD_W = 32;
	localparam logic [WORD_W-1:0] NONE_WORD = '1;

endpackage

FILE: design/cdq_req_if.sv
// Interface: request channel carrying a command and a word to push.
interface cdq_req_if;
	import cdq_pkg::*;

	logic               valid;
	logic               ready;
	cmd_t               cmd;
	logic signed [31:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

FILE: design/cdq_rsp_if.sv
// Interface: response channel carrying status, end words and occupancy flags.
interface cdq_rsp_if;
	import cdq_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic signed [31:0] front_value;
	logic signed [31:0] rear_value;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, output status, output front_value, output rear_value,
		output is_empty, output is_full, input ready);
	modport sink (input valid, input status, input front_value, input rear_value,
		input is_empty, input is_full, output ready);
endinterface

FILE: design/circular_deque.sv
// Top level: double-ended queue over a circular word store.
//
//   channel | direction | payload
//   req     | in        | cmd, value
//   rsp     | out       | status, front_value, rear_value, is_empty, is_full
//
// One request per cycle unless a stalled response fills the read stage.
// The response passes the store's registered read of both end words, then the output register.
// Reset empties the deque at once; store contents are left as they are.
// A stalled response holds the output register; one more request may sit in the read stage.
module circular_deque
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH      = 8,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	cdq_req_if.sink    req,
	cdq_rsp_if.source  rsp
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic                  accept, advance;
	logic                  we;
	logic [AW-1:0]         waddr, raddr_front, raddr_rear;
	logic [DATA_WIDTH-1:0] wdata, front_s1, rear_s1;
	info_t                 info, info_s1;
	logic                  valid_s1, out_valid_q;
	status_t               status_q;
	logic [WORD_W-1:0]     front_q, rear_q;
	logic                  empty_q, full_q;
	logic signed [63:0]    front_ext, rear_ext;

	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	cdq_ctrl #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (req.cmd),
		.value       (req.value),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.raddr_front (raddr_front),
		.raddr_rear  (raddr_rear),
		.info        (info)
	);

	cdq_mem #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_mem (
		.clk         (clk),
		.we          (we),
		.waddr       (waddr),
		.wdata       (wdata),
		.re          (accept),
		.raddr_front (raddr_front),
		.raddr_rear  (raddr_rear),
		.front_s1    (front_s1),
		.rear_s1     (rear_s1)
	);

	assign front_ext = 64'(signed'(front_s1));
	assign rear_ext  = 64'(signed'(rear_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
		if (valid_s1 && advance) begin
			status_q <= info_s1.status;
			empty_q <= info_s1.empty;
			full_q <= info_s1.full;
			front_q <= info_s1.empty ? NONE_WORD : front_ext[WORD_W-1:0];
			rear_q <= info_s1.empty ? NONE_WORD : rear_ext[WORD_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.front_value = front_q;
	assign rsp.rear_value  = rear_q;
	assign rsp.is_empty    = empty_q;
	assign rsp.is_full     = full_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !accept)
		else $error("request accepted over a stalled read stage");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.is_empty && rsp.is_full))
		else $error("response both empty and full");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.is_full)
		else $error("push refused while not full");

	a_empty_refused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EMPTY |-> rsp.is_empty)
		else $error("pop refused while not empty");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.is_empty |-> rsp.front_value == NONE_WORD
			&& rsp.rear_value == NONE_WORD)
		else $error("empty deque reports an end word");

endmodule

FILE: design/cdq_mem.sv
// Module: word store, one write port and two registered read ports with write forwarding.
module cdq_mem #(
	parameter int unsigned DEPTH      = 8,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned AW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr_front,
	input  logic [AW-1:0]         raddr_rear,
	output logic [DATA_WIDTH-1:0] front_s1,
	output logic [DATA_WIDTH-1:0] rear_s1
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// forward a same-cycle write to the reader
	always_ff @(posedge clk) begin
		if (re) begin
			front_s1 <= (we && waddr == raddr_front) ? wdata : mem_q[raddr_front];
			rear_s1  <= (we && waddr == raddr_rear) ? wdata : mem_q[raddr_rear];
		end
	end

endmodule

FILE: design/cdq_ctrl.sv
// Module: front and rear indices, empty mark, command decode and store access.
module cdq_ctrl
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH      = 8,
	parameter int unsigned DATA_WIDTH = 32,
	localparam int unsigned AW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  cmd_t                  cmd,
	input  logic signed [31:0]    value,
	output logic                  we,
	output logic [AW-1:0]         waddr,
	output logic [DATA_WIDTH-1:0] wdata,
	output logic [AW-1:0]         raddr_front,
	output logic [AW-1:0]         raddr_rear,
	output info_t                 info
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] head_q, tail_q, head_n, tail_n;
	logic          empty_q, empty_n;
	logic          full_now;
	logic signed [63:0] value_ext;
	status_t       status;

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] idx);
		return (idx == LAST) ? '0 : idx + AW'(1);
	endfunction

	function automatic logic [AW-1:0] dec(input logic [AW-1:0] idx);
		return (idx == '0) ? LAST : idx - AW'(1);
	endfunction

	assign full_now  = !empty_q && inc(tail_q) == head_q;
	assign value_ext = 64'(value);

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		empty_n = empty_q;
		status = ST_DONE;
		we = 1'b0;
		unique case (cmd) inside
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (full_now) begin
					status = ST_FULL;
				end else begin
					we = accept;
					if (empty_q) begin
						head_n = '0;
						tail_n = '0;
						empty_n = 1'b0;
					end else if (cmd == CMD_PUSH_FRONT) begin
						head_n = dec(head_q);
					end else begin
						tail_n = inc(tail_q);
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (empty_q) begin
					status = ST_EMPTY;
				end else if (head_q == tail_q) begin
					empty_n = 1'b1;
				end else if (cmd == CMD_POP_FRONT) begin
					head_n = inc(head_q);
				end else begin
					tail_n = dec(tail_q);
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign waddr       = (cmd == CMD_PUSH_FRONT) ? head_n : tail_n;
	assign wdata       = value_ext[DATA_WIDTH-1:0];
	assign raddr_front = head_n;
	assign raddr_rear  = tail_n;

	assign info.status = status;
	assign info.empty  = empty_n;
	assign info.full   = !empty_n && inc(tail_n) == head_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
		end else if (accept) begin
			head_q <= head_n;
			tail_q <= tail_n;
			empty_q <= empty_n;
		end
	end

endmodule
